@@ design/shlp_pkg.sv @@
// Shared types and constants of the spatial hash table.
package shlp_pkg;

  localparam int unsigned VAL_W     = 16;
  localparam int unsigned POS_W     = 24;
  localparam int unsigned CW_W      = 16;
  localparam int unsigned HASH_W    = 16;
  localparam int unsigned DIV_W     = 26;
  localparam int unsigned DCNT_W    = 5;
  localparam int unsigned RESULT_CAP = 64;
  localparam int unsigned NCNT_W    = 7;
  localparam logic [CW_W-1:0] PITCH_RESET = 16'd15360;
  // Only the low hash bits of each product survive the mask.
  localparam logic [HASH_W-1:0] PRIME_X_LO = 16'hF45D; // 73856093
  localparam logic [HASH_W-1:0] PRIME_Y_LO = 16'hFFB7; // 83492791

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_NBHD   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_LOAD,
    F_DIV,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_INIT,
    B_IDLE,
    B_RD,
    B_CHK,
    B_SWEEP,
    B_FIN
  } back_state_t;

  typedef struct packed {
    cmd_t              op;
    logic [HASH_W-1:0] hash;
    logic [VAL_W-1:0]  value;
    logic              last_cell;
  } task_t;

  typedef struct packed {
    logic [VAL_W-1:0] found_value;
    logic             found;
    logic             last;
    logic             status;
    logic             truncated;
  } res_t;

endpackage

@@ design/shlp_if.sv @@
// Handshake channels for command words and result words.
interface shlp_in_if;
  logic                valid;
  logic                ready;
  logic [1:0]          cmd;
  logic signed [23:0]  pos_x;
  logic signed [23:0]  pos_y;
  logic [15:0]         item_value;
  modport source (output valid, cmd, pos_x, pos_y, item_value, input ready);
  modport sink   (input valid, cmd, pos_x, pos_y, item_value, output ready);
endinterface

interface shlp_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] found_value;
  logic        found;
  logic        last;
  logic        status;
  logic        truncated;
  modport source (output valid, found_value, found, last, status, truncated, input ready);
  modport sink   (input valid, found_value, found, last, status, truncated, output ready);
endinterface

@@ design/shlp_div.sv @@
// Two-lane restoring divider: signed dividend by unsigned cell width, one bit per cycle.
module shlp_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic signed [shlp_pkg::DIV_W-1:0] num_x,
  input  logic signed [shlp_pkg::DIV_W-1:0] num_y,
  input  logic [shlp_pkg::CW_W-1:0]       den,
  output logic                            done,
  output logic [shlp_pkg::HASH_W-1:0]     q_x,
  output logic [shlp_pkg::HASH_W-1:0]     q_y
);
  import shlp_pkg::*;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic [CW_W-1:0]   den_r;
  logic [1:0]        neg_r;
  logic [DIV_W-1:0]  mag_r [2];
  logic [CW_W-1:0]   rem_r [2];
  logic [DIV_W-1:0]  num_mag [2];
  logic [CW_W:0]     trial [2];

  assign num_mag[0] = num_x[DIV_W-1] ? DIV_W'(-num_x) : DIV_W'(num_x);
  assign num_mag[1] = num_y[DIV_W-1] ? DIV_W'(-num_y) : DIV_W'(num_y);

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + DCNT_W'(1);
      if (cnt_r == DCNT_W'(DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    assign trial[l] = {rem_r[l], mag_r[l][DIV_W-1]};
    always_ff @(posedge clk) begin
      if (start) begin
        mag_r[l] <= num_mag[l];
        rem_r[l] <= '0;
      end else if (busy_r) begin
        if (trial[l] >= {1'b0, den_r}) begin
          rem_r[l] <= CW_W'(trial[l] - {1'b0, den_r});
          mag_r[l] <= {mag_r[l][DIV_W-2:0], 1'b1};
        end else begin
          rem_r[l] <= CW_W'(trial[l]);
          mag_r[l] <= {mag_r[l][DIV_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      neg_r <= {num_y[DIV_W-1], num_x[DIV_W-1]};
    end
  end

  // Truncate toward zero: negate the magnitude quotient for a negative dividend.
  assign q_x  = neg_r[0] ? HASH_W'(-mag_r[0][HASH_W-1:0]) : mag_r[0][HASH_W-1:0];
  assign q_y  = neg_r[1] ? HASH_W'(-mag_r[1][HASH_W-1:0]) : mag_r[1][HASH_W-1:0];
  assign done = done_r;

endmodule

@@ design/shlp_front.sv @@
// Front end: accept commands, hash each probed cell and queue the work.
module shlp_front #(
  parameter int unsigned NUM_CELLS = 256
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_cmd,
  input  logic signed [shlp_pkg::POS_W-1:0] in_pos_x,
  input  logic signed [shlp_pkg::POS_W-1:0] in_pos_y,
  input  logic [shlp_pkg::VAL_W-1:0]  in_value,
  input  logic [shlp_pkg::CW_W-1:0]   pitch,
  input  logic                        init_busy,
  output logic                        task_valid,
  input  logic                        task_ready,
  output shlp_pkg::task_t             task_data
);
  import shlp_pkg::*;

  localparam logic [HASH_W-1:0] HMASK = HASH_W'(NUM_CELLS - 1);

  front_state_t            state_r, state_nxt;
  cmd_t                    cmd_r;
  logic signed [POS_W-1:0] px_r, py_r;
  logic [VAL_W-1:0]        val_r;
  logic [CW_W-1:0]         w_r;
  logic [1:0]              dx_r, dx_nxt, dy_r, dy_nxt;
  logic [HASH_W-1:0]       prodx_r, prody_r;
  logic                    div_start, div_done;
  logic [HASH_W-1:0]       q_x, q_y;
  logic signed [DIV_W-1:0] num_x, num_y, px_ext, py_ext, w_ext;
  logic                    last_cell;
  logic                    accept;

  assign accept = in_valid && in_ready;
  assign px_ext = {{(DIV_W-POS_W){px_r[POS_W-1]}}, px_r};
  assign py_ext = {{(DIV_W-POS_W){py_r[POS_W-1]}}, py_r};
  assign w_ext  = {{(DIV_W-CW_W){1'b0}}, w_r};

  // Step 0 is minus one cell, step 2 plus one cell.
  always_comb begin
    case (dx_r)
      2'd0:    num_x = px_ext - w_ext;
      2'd2:    num_x = px_ext + w_ext;
      default: num_x = px_ext;
    endcase
    case (dy_r)
      2'd0:    num_y = py_ext - w_ext;
      2'd2:    num_y = py_ext + w_ext;
      default: num_y = py_ext;
    endcase
  end

  shlp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num_x (num_x),
    .num_y (num_y),
    .den   (w_r),
    .done  (div_done),
    .q_x   (q_x),
    .q_y   (q_y)
  );

  assign last_cell = (cmd_r != CMD_NBHD) || (dx_r == 2'd2 && dy_r == 2'd2);

  always_comb begin
    state_nxt  = state_r;
    dx_nxt     = dx_r;
    dy_nxt     = dy_r;
    in_ready   = 1'b0;
    div_start  = 1'b0;
    task_valid = 1'b0;
    task_data.op        = cmd_r;
    task_data.hash      = (prodx_r ^ prody_r) & HMASK;
    task_data.value     = val_r;
    task_data.last_cell = last_cell;
    unique case (state_r)
      F_IDLE: begin
        in_ready = !init_busy;
        if (accept) begin
          state_nxt = (cmd_t'(in_cmd) == CMD_CLEAR) ? F_PUSH : F_LOAD;
          // A single-cell command uses the center offsets.
          dx_nxt = (cmd_t'(in_cmd) == CMD_NBHD) ? 2'd0 : 2'd1;
          dy_nxt = (cmd_t'(in_cmd) == CMD_NBHD) ? 2'd0 : 2'd1;
        end
      end
      F_LOAD: begin
        div_start = 1'b1;
        state_nxt = F_DIV;
      end
      F_DIV: begin
        if (div_done) state_nxt = F_PUSH;
      end
      F_PUSH: begin
        task_valid = 1'b1;
        if (task_ready) begin
          if (last_cell) begin
            state_nxt = F_IDLE;
          end else begin
            state_nxt = F_LOAD;
            if (dx_r == 2'd2) begin
              dx_nxt = 2'd0;
              dy_nxt = dy_r + 2'd1;
            end else begin
              dx_nxt = dx_r + 2'd1;
            end
          end
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      dx_r    <= 2'd1;
      dy_r    <= 2'd1;
    end else begin
      state_r <= state_nxt;
      dx_r    <= dx_nxt;
      dy_r    <= dy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= cmd_t'(in_cmd);
      px_r  <= in_pos_x;
      py_r  <= in_pos_y;
      val_r <= in_value;
      w_r   <= (pitch == '0) ? CW_W'(1) : pitch;
    end
    if (state_r == F_PUSH && cmd_r == CMD_CLEAR) begin
      prodx_r <= '0;
      prody_r <= '0;
    end else if (div_done) begin
      prodx_r <= HASH_W'(q_x * PRIME_X_LO);
      prody_r <= HASH_W'(q_y * PRIME_Y_LO);
    end
  end

endmodule

@@ design/shlp_fifo.sv @@
// Short queue of hashed work words between front and back.
module shlp_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  shlp_pkg::task_t push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output shlp_pkg::task_t pop_data
);
  import shlp_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  task_t             q_mem [DEPTH];
  logic [PTR_W-1:0]  wr_r, rd_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              do_push, do_pop;

  assign push_ready = (cnt_r != CNT_W'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_data   = q_mem[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wr_r <= (wr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_r + PTR_W'(1);
      if (do_pop)  rd_r <= (rd_r == PTR_W'(DEPTH - 1)) ? '0 : rd_r + PTR_W'(1);
      if (do_push && !do_pop)      cnt_r <= cnt_r + CNT_W'(1);
      else if (do_pop && !do_push) cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) q_mem[wr_r] <= push_data;
  end

endmodule

@@ design/shlp_back.sv @@
// Back end: slot memory, linear probing, result word formation.
module shlp_back #(
  parameter int unsigned NUM_CELLS      = 256,
  parameter int unsigned ITEMS_PER_CELL = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            task_valid,
  output logic            task_ready,
  input  shlp_pkg::task_t task_data,
  output logic            init_busy,
  output logic            out_valid,
  input  logic            out_ready,
  output shlp_pkg::res_t  out_word
);
  import shlp_pkg::*;

  localparam int unsigned ENTRY = NUM_CELLS * ITEMS_PER_CELL;
  localparam int unsigned AW    = $clog2(ENTRY);
  localparam int unsigned HB    = $clog2(NUM_CELLS);
  localparam int unsigned EW    = 1 + HB + VAL_W;

  logic [EW-1:0]     mem [ENTRY];
  logic [EW-1:0]     rd_r;
  logic              we;
  logic [EW-1:0]     wdata;

  back_state_t       state_r, state_nxt;
  task_t             cur_r;
  logic [AW-1:0]     idx_r, idx_nxt, probes_r, probes_nxt, idx_inc;
  logic [NCNT_W-1:0] n_r, n_nxt;
  logic              pend_v_r, pend_v_nxt;
  logic [VAL_W-1:0]  pend_val_r, pend_val_nxt;
  logic              ovf_r, ovf_nxt, status_r, status_nxt;
  logic              out_valid_r, out_load, out_free;
  res_t              out_word_r, out_load_word;
  logic              ent_v, match, last_probe, under_cap, take;
  logic [HB-1:0]     ent_h, cur_h;
  logic [VAL_W-1:0]  ent_d;

  assign ent_v      = rd_r[EW-1];
  assign ent_h      = rd_r[EW-2 -: HB];
  assign ent_d      = rd_r[VAL_W-1:0];
  assign cur_h      = cur_r.hash[HB-1:0];
  assign match      = ent_v && (ent_h == cur_h);
  assign last_probe = (probes_r == AW'(ENTRY - 1));
  assign under_cap  = (n_r < NCNT_W'(RESULT_CAP));
  assign idx_inc    = (idx_r == AW'(ENTRY - 1)) ? '0 : idx_r + AW'(1);
  assign out_free   = !out_valid_r || out_ready;
  assign take       = task_valid && task_ready;
  assign init_busy  = (state_r == B_INIT);

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    probes_nxt    = probes_r;
    n_nxt         = n_r;
    pend_v_nxt    = pend_v_r;
    pend_val_nxt  = pend_val_r;
    ovf_nxt       = ovf_r;
    status_nxt    = status_r;
    task_ready    = 1'b0;
    we            = 1'b0;
    wdata         = '0;
    out_load      = 1'b0;
    out_load_word = '{found_value: pend_val_r, found: 1'b1, last: 1'b0,
                      status: 1'b0, truncated: 1'b0};
    unique case (state_r) inside
      B_INIT, B_SWEEP: begin
        // Invalidate one slot per cycle.
        we = 1'b1;
        if (idx_r == AW'(ENTRY - 1)) begin
          idx_nxt   = '0;
          state_nxt = (state_r == B_INIT) ? B_IDLE : B_FIN;
        end else begin
          idx_nxt = idx_inc;
        end
      end
      B_IDLE: begin
        task_ready = 1'b1;
        if (task_valid) begin
          probes_nxt = '0;
          if (task_data.op == CMD_CLEAR) begin
            idx_nxt   = '0;
            state_nxt = B_SWEEP;
          end else begin
            idx_nxt   = AW'(task_data.hash[HB-1:0]) * AW'(ITEMS_PER_CELL);
            state_nxt = B_RD;
          end
        end
      end
      B_RD: state_nxt = B_CHK;
      B_CHK: begin
        if (cur_r.op == CMD_INSERT) begin
          if (!ent_v) begin
            we         = 1'b1;
            wdata      = {1'b1, cur_h, cur_r.value};
            status_nxt = 1'b0;
            state_nxt  = B_FIN;
          end else if (last_probe) begin
            status_nxt = 1'b1;
            state_nxt  = B_FIN;
          end else begin
            idx_nxt    = idx_inc;
            probes_nxt = probes_r + AW'(1);
            state_nxt  = B_RD;
          end
        end else if (!(match && under_cap && pend_v_r && !out_free)) begin
          if (match) begin
            if (under_cap) begin
              // Release the held match; the newest one waits to learn if it is final.
              out_load     = pend_v_r;
              pend_v_nxt   = 1'b1;
              pend_val_nxt = ent_d;
              n_nxt        = n_r + NCNT_W'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
          end
          if (!ent_v || last_probe) begin
            state_nxt = cur_r.last_cell ? B_FIN : B_IDLE;
          end else begin
            idx_nxt    = idx_inc;
            probes_nxt = probes_r + AW'(1);
            state_nxt  = B_RD;
          end
        end
      end
      B_FIN: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_load_word = '{found_value: pend_v_r ? pend_val_r : '0, found: pend_v_r,
                            last: 1'b1, status: status_r, truncated: pend_v_r && ovf_r};
          pend_v_nxt    = 1'b0;
          n_nxt         = '0;
          ovf_nxt       = 1'b0;
          status_nxt    = 1'b0;
          state_nxt     = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_INIT;
      idx_r       <= '0;
      probes_r    <= '0;
      n_r         <= '0;
      pend_v_r    <= 1'b0;
      ovf_r       <= 1'b0;
      status_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      idx_r    <= idx_nxt;
      probes_r <= probes_nxt;
      n_r      <= n_nxt;
      pend_v_r <= pend_v_nxt;
      ovf_r    <= ovf_nxt;
      status_r <= status_nxt;
      if (out_load)       out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    pend_val_r <= pend_val_nxt;
    if (take)     cur_r      <= task_data;
    if (out_load) out_word_r <= out_load_word;
  end

  always_ff @(posedge clk) begin
    if (we) mem[idx_r] <= wdata;
    rd_r <= mem[idx_r];
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

@@ design/spatial_hash_linear_probe_table_top.sv @@
// Top level of the spatial hash table with linear probing.
// A command word is taken in, its cell (or each of the nine cells of the 3x3
// neighborhood, row by row, lowest coordinates first) is hashed by the front
// end, and the hashed cell goes through a four-deep queue to the back end,
// which probes the slot memory slot by slot, each slot with a registered read
// and then a compare. Each hashed cell passes the front end states load,
// divide and push, the divide done by the 26-step bit-serial divider by the
// cell width; the front end hashes the next cell while the back end probes. A
// clear walks the whole slot memory, NUM_CELLS * ITEMS_PER_CELL slots. After
// reset the same pass runs once and no command word is taken until it ends;
// the cell width may be written at any time during it. Query matches leave as
// result words in probe order, at most 64 per command, the final one flagged
// last and truncated when more matches existed; a query with no match, and
// every clear or insert, returns a single last word. The result register lets
// the back end go on while a word waits to be taken.
module spatial_hash_linear_probe_table_top #(
  parameter int unsigned NUM_CELLS      = 256,
  parameter int unsigned ITEMS_PER_CELL = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [shlp_pkg::CW_W-1:0]    cfg_wdata,
  shlp_in_if.sink                      in_ch,
  shlp_out_if.source                   out_ch
);
  import shlp_pkg::*;

  logic [CW_W-1:0] pitch_r;
  logic            task_valid, task_ready, pop_valid, pop_ready;
  task_t           task_data, pop_data;
  logic            init_busy;
  res_t            out_word;

  // Hold the cell width until the next write.
  always_ff @(posedge clk) begin
    if (!rst_n)      pitch_r <= PITCH_RESET;
    else if (cfg_we) pitch_r <= cfg_wdata;
  end

  shlp_front #(.NUM_CELLS(NUM_CELLS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_cmd     (in_ch.cmd),
    .in_pos_x   (in_ch.pos_x),
    .in_pos_y   (in_ch.pos_y),
    .in_value   (in_ch.item_value),
    .pitch      (pitch_r),
    .init_busy  (init_busy),
    .task_valid (task_valid),
    .task_ready (task_ready),
    .task_data  (task_data)
  );

  shlp_fifo #(.DEPTH(4)) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (task_valid),
    .push_ready (task_ready),
    .push_data  (task_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  shlp_back #(.NUM_CELLS(NUM_CELLS), .ITEMS_PER_CELL(ITEMS_PER_CELL)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .task_valid (pop_valid),
    .task_ready (pop_ready),
    .task_data  (pop_data),
    .init_busy  (init_busy),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_word   (out_word)
  );

  assign out_ch.found_value = out_word.found_value;
  assign out_ch.found       = out_word.found;
  assign out_ch.last        = out_word.last;
  assign out_ch.status      = out_word.status;
  assign out_ch.truncated   = out_word.truncated;

endmodule

@@ design/shlp_checker.sv @@
// Port-level checks of the result channel, bound to the top level.
module shlp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_found_value,
  input logic        out_found,
  input logic        out_last,
  input logic        out_status,
  input logic        out_truncated
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_found_value) && $stable(out_last))
    else $error("result word changed while stalled");

  a_full_no_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> !out_found && out_last)
    else $error("full status on a non-final or matching word");

  a_trunc_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_truncated |-> out_found && out_last)
    else $error("truncated flag off the final match");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_found_value == 16'd0 && out_last)
    else $error("empty result word not final or not zero");

endmodule

bind spatial_hash_linear_probe_table_top shlp_checker u_shlp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_found_value (out_ch.found_value),
  .out_found       (out_ch.found),
  .out_last        (out_ch.last),
  .out_status      (out_ch.status),
  .out_truncated   (out_ch.truncated)
);
